### hdl/vlan_tag_classify_insert_unit_defines.svh
// assertion macros for the vlan tag unit
// both use clk_i as the sampling clock and are named by the caller
`ifndef VLAN_TAG_CLASSIFY_INSERT_UNIT_DEFINES_SVH
`define VLAN_TAG_CLASSIFY_INSERT_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// checked only outside reset
`define VTAG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define VTAG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define VTAG_ASSERT(lbl, prop, msg)

`define VTAG_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### hdl/vtag_pkg.sv
`default_nettype none

package vtag_pkg;

  // table depth default and number of physical parent ports
  localparam int NumVlansDefault = 16;
  localparam int NUM_PORTS = 8;

  localparam logic [15:0] TPID_CTAG = 16'h8100;
  localparam logic [15:0] TPID_STAG = 16'h88A8;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_RX    = 2'd1,
    CMD_TX    = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_UP      = 2'd0,
    REG_RUNNING = 2'd1,
    REG_PROMISC = 2'd2,
    REG_HWTAG   = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    V_DELIVER      = 4'd0,
    V_NOT_VLAN     = 4'd1,
    V_PORT_DOWN    = 4'd2,
    V_HDR_ERR      = 4'd3,
    V_NO_MATCH     = 4'd4,
    V_VLAN_DOWN    = 4'd5,
    V_PROMISC_FILT = 4'd6,
    V_TX_DOWN      = 4'd7,
    V_WRITTEN      = 4'd8
  } verdict_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_TXRD,
    ST_DONE
  } state_e;

  // table entry, valid in bit 0
  typedef struct packed {
    logic        promisc;
    logic        up;
    logic        qinq;
    logic [11:0] vid;
    logic [2:0]  port;
    logic        valid;
  } entry_t;

  localparam int EntryW = $bits(entry_t);
  localparam int MacW = 48;

  // result item, verdict in the lowest bits
  typedef struct packed {
    logic [15:0] out_tag_word;
    logic [15:0] out_ethertype;
    logic        hw_tag_mode;
    logic [2:0]  priority_res;
    logic [11:0] vlan_id;
    logic [3:0]  match_index;
    verdict_e    verdict;
  } result_t;

  // 802.1p priorities 0 and 1 trade places
  function automatic logic [2:0] swap_prio(input logic [2:0] p);
    swap_prio = (p <= 3'd1) ? (p ^ 3'd1) : p;
  endfunction

endpackage

`default_nettype wire

### hdl/vtag_ram.sv
`default_nettype none

module vtag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/vlan_tag_classify_insert_unit.sv
`default_nettype none
`include "vlan_tag_classify_insert_unit_defines.svh"

// vlan tag classify / insert unit
// input stream (s_axis): one command per transfer, command kind in tuser
//   write entry, classify a received header, or build a transmit tag
// output stream (m_axis): exactly one result transfer per input transfer, in order
// config port: cfg_we_i writes one of four per-port masks (up, running,
//   promisc, hw tag) at index cfg_addr_i; write only while the unit is idle
// timing: one command is in flight at a time
//   write, unknown command and early receive drops: ST_DONE, then output register
//   transmit: ST_TXRD (one table read), then ST_DONE
//   receive with a table lookup: ST_SCAN, the one-entry-per-cycle scan
//   through the table ram read port, stopping early at the first matching
//   entry, then ST_DONE
// reset: the table is swept to all-invalid, one entry per cycle, in ST_CLEAR,
//   during which s_axis_tready_o is low; masks reset to zero
// stall: a finished result sits in the output register while the next
//   command is taken; a second result waits inside until m_axis_tready_i
module vlan_tag_classify_insert_unit #(
  parameter int NUM_VLANS = vtag_pkg::NumVlansDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input command stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [2:0] port, [6:3] entry_index, [22:7] ethertype, [38:23] tag_word,
  // [39] hw_tag_present, [40] short_header, [88:41] mac_addr,
  // [91:89] tx_priority, [95:92] entry_flags
  input  wire logic [95:0] s_axis_tdata_i,
  // [1:0] command
  input  wire logic [1:0]  s_axis_tuser_i,
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [3:0] verdict, [7:4] match_index, [19:8] vlan_id, [22:20] priority_res,
  // [23] hw_tag_mode, [39:24] out_ethertype, [55:40] out_tag_word
  output logic      [55:0] m_axis_tdata_o,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [7:0]  cfg_wdata_i
);

  localparam int AW = (NUM_VLANS > 1) ? $clog2(NUM_VLANS) : 1;
  localparam int CW = $clog2(NUM_VLANS + 1);

  // per-port masks
  logic [7:0] up_mask_q, running_mask_q, promisc_mask_q, hwtag_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_mask_q      <= '0;
      running_mask_q <= '0;
      promisc_mask_q <= '0;
      hwtag_mask_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (vtag_pkg::cfg_reg_e'(cfg_addr_i))
        vtag_pkg::REG_UP:      up_mask_q      <= cfg_wdata_i;
        vtag_pkg::REG_RUNNING: running_mask_q <= cfg_wdata_i;
        vtag_pkg::REG_PROMISC: promisc_mask_q <= cfg_wdata_i;
        vtag_pkg::REG_HWTAG:   hwtag_mask_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input field unpacking
  vtag_pkg::cmd_e in_cmd;
  logic [2:0]  in_port;
  logic [3:0]  in_idx;
  logic [15:0] in_etype, in_tci;
  logic        in_hw, in_short;
  logic [47:0] in_mac;
  logic [2:0]  in_txprio;
  logic [3:0]  in_flags;

  assign in_cmd    = vtag_pkg::cmd_e'(s_axis_tuser_i);
  assign in_port   = s_axis_tdata_i[2:0];
  assign in_idx    = s_axis_tdata_i[6:3];
  assign in_etype  = s_axis_tdata_i[22:7];
  assign in_tci    = s_axis_tdata_i[38:23];
  assign in_hw     = s_axis_tdata_i[39];
  assign in_short  = s_axis_tdata_i[40];
  assign in_mac    = s_axis_tdata_i[88:41];
  assign in_txprio = s_axis_tdata_i[91:89];
  assign in_flags  = s_axis_tdata_i[95:92];

  vtag_pkg::state_e state_q, state_d;

  logic acc;
  assign s_axis_tready_o = (state_q == vtag_pkg::ST_IDLE);
  assign acc = s_axis_tvalid_i && s_axis_tready_o;

  logic in_idx_ok, in_port_up, in_tpid, in_qinq;
  assign in_idx_ok  = (32'(in_idx) < 32'(NUM_VLANS));
  assign in_port_up = (32'(in_port) < 32'(vtag_pkg::NUM_PORTS)) && up_mask_q[in_port];
  assign in_qinq    = !in_hw && (in_etype == vtag_pkg::TPID_STAG);
  assign in_tpid    = (in_etype == vtag_pkg::TPID_CTAG) || (in_etype == vtag_pkg::TPID_STAG);

  // command held for the scan / table read
  logic [2:0]  port_q, txprio_q;
  logic [3:0]  idx_q;
  logic [11:0] vid_q;
  logic [2:0]  prio_q;
  logic        qinq_q, hw_q;
  logic [47:0] dmac_q;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      port_q   <= in_port;
      idx_q    <= in_idx;
      vid_q    <= in_tci[11:0];
      prio_q   <= vtag_pkg::swap_prio(in_tci[15:13]);
      qinq_q   <= in_qinq;
      hw_q     <= in_hw;
      dmac_q   <= in_mac;
      txprio_q <= in_txprio;
    end
  end

  // table rams, shared read address
  logic                ent_we, mac_we, rd_en;
  logic [AW-1:0]       ent_waddr, raddr;
  vtag_pkg::entry_t    ent_wdata, ent_rd;
  logic [vtag_pkg::EntryW-1:0] ent_rdata;
  logic [vtag_pkg::MacW-1:0]   mac_rdata;

  vtag_ram #(
    .WIDTH (vtag_pkg::EntryW),
    .DEPTH (NUM_VLANS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (ent_rdata)
  );

  vtag_ram #(
    .WIDTH (vtag_pkg::MacW),
    .DEPTH (NUM_VLANS)
  ) u_mac_ram (
    .clk_i   (clk_i),
    .we_i    (mac_we),
    .waddr_i (AW'(in_idx)),
    .wdata_i (in_mac),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (mac_rdata)
  );

  assign ent_rd = vtag_pkg::entry_t'(ent_rdata);

  // clear sweep and scan pointers
  logic [AW-1:0] clr_q;
  logic [CW-1:0] issue_q, issue_d, cmp_q;
  logic          rd_vld_q;
  logic          clr_last, scan_hit, scan_last, scan_done;

  assign clr_last  = (clr_q == AW'(NUM_VLANS - 1));
  assign scan_hit  = ent_rd.valid && (ent_rd.port == port_q) && (ent_rd.vid == vid_q) &&
                     (ent_rd.qinq == qinq_q);
  assign scan_last = (cmp_q == CW'(NUM_VLANS - 1));
  assign scan_done = rd_vld_q && (scan_hit || scan_last);

  // transmit parent checks on the entry just read
  logic tx_up, tx_hw;
  assign tx_up = (32'(ent_rd.port) < 32'(vtag_pkg::NUM_PORTS)) &&
                 up_mask_q[ent_rd.port] && running_mask_q[ent_rd.port];
  assign tx_hw = hwtag_mask_q[ent_rd.port] && !ent_rd.qinq;

  logic rx_promisc_drop;
  assign rx_promisc_drop = !dmac_q[40] && promisc_mask_q[port_q] &&
                           (32'(port_q) < 32'(vtag_pkg::NUM_PORTS)) &&
                           !ent_rd.promisc && (mac_rdata != dmac_q);

  // result holding register and output register
  vtag_pkg::result_t res_q, res_d, out_q;
  logic              res_load, out_free, out_load, m_valid_q;

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign out_load = (state_q == vtag_pkg::ST_DONE) && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vtag_pkg::ST_CLEAR: begin
        if (clr_last) state_d = vtag_pkg::ST_IDLE;
      end
      vtag_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (in_cmd)
            vtag_pkg::CMD_RX: begin
              if (in_port_up && (in_hw || (in_tpid && !in_short))) begin
                state_d = vtag_pkg::ST_SCAN;
              end else begin
                state_d = vtag_pkg::ST_DONE;
              end
            end
            vtag_pkg::CMD_TX: begin
              state_d = in_idx_ok ? vtag_pkg::ST_TXRD : vtag_pkg::ST_DONE;
            end
            default: state_d = vtag_pkg::ST_DONE;
          endcase
        end
      end
      vtag_pkg::ST_SCAN: begin
        if (scan_done) state_d = vtag_pkg::ST_DONE;
      end
      vtag_pkg::ST_TXRD: state_d = vtag_pkg::ST_DONE;
      vtag_pkg::ST_DONE: begin
        if (out_free) state_d = vtag_pkg::ST_IDLE;
      end
      default: state_d = vtag_pkg::ST_IDLE;
    endcase
  end

  // datapath control and result forming
  always_comb begin
    ent_we    = 1'b0;
    mac_we    = 1'b0;
    ent_waddr = AW'(in_idx);
    ent_wdata = '0;
    rd_en     = 1'b0;
    raddr     = AW'(in_idx);
    issue_d   = issue_q;
    res_load  = 1'b0;
    res_d     = '0;
    res_d.verdict = vtag_pkg::V_NOT_VLAN;
    unique case (state_q)
      vtag_pkg::ST_CLEAR: begin
        ent_we    = 1'b1;
        ent_waddr = clr_q;
      end
      vtag_pkg::ST_IDLE: begin
        issue_d = '0;
        if (acc) begin
          res_load = 1'b1;
          unique case (in_cmd)
            vtag_pkg::CMD_WRITE: begin
              ent_we            = in_idx_ok;
              mac_we            = in_idx_ok;
              ent_wdata.valid   = in_flags[0];
              ent_wdata.port    = in_port;
              ent_wdata.vid     = in_tci[11:0];
              ent_wdata.qinq    = in_flags[1];
              ent_wdata.up      = in_flags[2];
              ent_wdata.promisc = in_flags[3];
              res_d.verdict     = vtag_pkg::V_WRITTEN;
              res_d.match_index = in_idx;
              res_d.vlan_id     = in_tci[11:0];
            end
            vtag_pkg::CMD_RX: begin
              priority if (!in_port_up) begin
                res_d.verdict = vtag_pkg::V_PORT_DOWN;
              end else if (!in_hw && !in_tpid) begin
                res_d.verdict = vtag_pkg::V_NOT_VLAN;
              end else if (!in_hw && in_short) begin
                res_d.verdict = vtag_pkg::V_HDR_ERR;
              end else begin
                res_load = 1'b0;
              end
            end
            vtag_pkg::CMD_TX: begin
              rd_en             = in_idx_ok;
              res_load          = !in_idx_ok;
              res_d.verdict     = vtag_pkg::V_TX_DOWN;
              res_d.match_index = in_idx;
            end
            vtag_pkg::CMD_NOP: res_d.verdict = vtag_pkg::V_NOT_VLAN;
            default: ;
          endcase
        end
      end
      vtag_pkg::ST_SCAN: begin
        // one read issued per cycle, compared in the cycle after
        rd_en = (issue_q < CW'(NUM_VLANS));
        raddr = issue_q[AW-1:0];
        if (rd_en) issue_d = CW'(issue_q + 1'b1);
        res_load           = scan_done;
        res_d.vlan_id      = vid_q;
        res_d.priority_res = prio_q;
        priority if (!scan_hit) begin
          res_d.verdict = vtag_pkg::V_NO_MATCH;
        end else if (!ent_rd.up) begin
          res_d.verdict     = vtag_pkg::V_VLAN_DOWN;
          res_d.match_index = 4'(cmp_q);
        end else if (rx_promisc_drop) begin
          res_d.verdict     = vtag_pkg::V_PROMISC_FILT;
          res_d.match_index = 4'(cmp_q);
        end else begin
          res_d.verdict     = vtag_pkg::V_DELIVER;
          res_d.match_index = 4'(cmp_q);
          res_d.hw_tag_mode = hw_q;
        end
      end
      vtag_pkg::ST_TXRD: begin
        res_load          = 1'b1;
        res_d.match_index = idx_q;
        if (!ent_rd.valid || !tx_up) begin
          res_d.verdict = vtag_pkg::V_TX_DOWN;
        end else begin
          res_d.verdict      = vtag_pkg::V_DELIVER;
          res_d.vlan_id      = ent_rd.vid;
          res_d.priority_res = vtag_pkg::swap_prio(txprio_q);
          res_d.out_tag_word = {vtag_pkg::swap_prio(txprio_q), 1'b0, ent_rd.vid};
          res_d.hw_tag_mode  = tx_hw;
          if (!tx_hw) begin
            res_d.out_ethertype = ent_rd.qinq ? vtag_pkg::TPID_STAG : vtag_pkg::TPID_CTAG;
          end
        end
      end
      vtag_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= vtag_pkg::ST_CLEAR;
      clr_q     <= '0;
      issue_q   <= '0;
      cmp_q     <= '0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == vtag_pkg::ST_CLEAR) clr_q <= AW'(clr_q + 1'b1);
      issue_q  <= issue_d;
      cmp_q    <= issue_q;
      rd_vld_q <= (state_q == vtag_pkg::ST_SCAN) && rd_en;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) res_q <= res_d;
    if (out_load) out_q <= res_q;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_q;

  // table is written only by the clear sweep or a write command, never mid-lookup
  `VTAG_ASSERT(a_table_write_when_idle,
    ent_we |-> (state_q == vtag_pkg::ST_CLEAR || state_q == vtag_pkg::ST_IDLE),
    "table written during a lookup")
  // compared entry always lies inside the table
  `VTAG_ASSERT(a_scan_in_range, rd_vld_q |-> (cmp_q < CW'(NUM_VLANS)),
    "scan compared past the table end")
  // a finished result handed over shows up on the output next cycle
  `VTAG_ASSERT(a_result_presented, out_load |=> m_axis_tvalid_o,
    "result lost between holding and output register")
  // no command is taken while the table sweep runs
  `VTAG_ASSERT_ALWAYS(a_no_accept_in_clear,
    (state_q == vtag_pkg::ST_CLEAR) |-> !s_axis_tready_o,
    "command accepted during table clear")

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int NV = vtag_pkg::NumVlansDefault;
  // long receiver hold-off, enough to back the unit up into its input
  localparam int HoldOffCycles = 200;

  // input transfer fields in tdata order, port in the lowest bits
  typedef struct packed {
    logic [3:0]  flags;
    logic [2:0]  txprio;
    logic [47:0] mac;
    logic        shorth;
    logic        hw;
    logic [15:0] tci;
    logic [15:0] etype;
    logic [3:0]  idx;
    logic [2:0]  port;
  } cmd_fields_t;

  // one directed row; want is used only where typed is set
  typedef struct {
    vtag_pkg::cmd_e    cmd;
    cmd_fields_t       f;
    bit                typed;
    vtag_pkg::result_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0]  s_tuser = vtag_pkg::CMD_NOP;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = vtag_pkg::REG_UP;
  logic [7:0]  cfg_wdata = '0;

  // shadow of the vlan table and the per-port masks
  vtag_pkg::entry_t entry_tab [NV];
  logic [47:0]      mac_tab [NV];
  logic [7:0]       mask_up, mask_run, mask_promisc, mask_hwtag;

  // results still owed by the unit, oldest first
  vtag_pkg::result_t exp_q [$];
  int                fail_cnt = 0;

  // idling controls set by the stimulus; rx_idle_en and hold_off_req steer the result side
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          hold_off_req = 1'b0;

  logic [11:0] vid_pool [4] = '{12'h000, 12'hFFF, 12'h005, 12'h123};

  dir_row_t    rows [$];

  vlan_tag_classify_insert_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // hard stop in case the unit hangs
  initial begin : watchdog
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // 802.1p code points 0 and 1 trade places
  function automatic logic [2:0] pcp_swap(input logic [2:0] p);
    case (p)
      3'd0:    pcp_swap = 3'd1;
      3'd1:    pcp_swap = 3'd0;
      default: pcp_swap = p;
    endcase
  endfunction

  // expected result of one command; a table write updates the shadow
  function automatic vtag_pkg::result_t vlan_predict(input vtag_pkg::cmd_e c,
                                                     input cmd_fields_t f);
    vtag_pkg::result_t r;
    vtag_pkg::entry_t  e;
    logic              qinq;
    int                hit;
    r = '0;
    case (c)
      vtag_pkg::CMD_WRITE: begin
        e = '0;
        e.valid   = f.flags[0];
        e.qinq    = f.flags[1];
        e.up      = f.flags[2];
        e.promisc = f.flags[3];
        e.port    = f.port;
        e.vid     = f.tci[11:0];
        entry_tab[f.idx] = e;
        mac_tab[f.idx]   = f.mac;
        r.verdict     = vtag_pkg::V_WRITTEN;
        r.match_index = f.idx;
        r.vlan_id     = f.tci[11:0];
      end
      vtag_pkg::CMD_RX: begin
        if (!mask_up[f.port]) begin
          r.verdict = vtag_pkg::V_PORT_DOWN;
        end else if (!f.hw && f.etype != vtag_pkg::TPID_CTAG &&
                     f.etype != vtag_pkg::TPID_STAG) begin
          r.verdict = vtag_pkg::V_NOT_VLAN;
        end else if (!f.hw && f.shorth) begin
          r.verdict = vtag_pkg::V_HDR_ERR;
        end else begin
          // a hardware tag always counts as a plain 802.1q tag
          qinq = !f.hw && (f.etype == vtag_pkg::TPID_STAG);
          r.vlan_id      = f.tci[11:0];
          r.priority_res = pcp_swap(f.tci[15:13]);
          hit = -1;
          for (int i = NV - 1; i >= 0; i--) begin
            if (entry_tab[i].valid && entry_tab[i].port == f.port &&
                entry_tab[i].vid == f.tci[11:0] && entry_tab[i].qinq == qinq)
              hit = i;
          end
          if (hit < 0) begin
            r.verdict = vtag_pkg::V_NO_MATCH;
          end else begin
            r.match_index = 4'(hit);
            if (!entry_tab[hit].up) begin
              r.verdict = vtag_pkg::V_VLAN_DOWN;
            end else if (!f.mac[40] && mask_promisc[f.port] && !entry_tab[hit].promisc &&
                         mac_tab[hit] != f.mac) begin
              r.verdict = vtag_pkg::V_PROMISC_FILT;
            end else begin
              r.verdict     = vtag_pkg::V_DELIVER;
              r.hw_tag_mode = f.hw;
            end
          end
        end
      end
      vtag_pkg::CMD_TX: begin
        e = entry_tab[f.idx];
        r.match_index = f.idx;
        if (!e.valid || !mask_up[e.port] || !mask_run[e.port]) begin
          r.verdict = vtag_pkg::V_TX_DOWN;
        end else begin
          r.verdict      = vtag_pkg::V_DELIVER;
          r.vlan_id      = e.vid;
          r.priority_res = pcp_swap(f.txprio);
          r.out_tag_word = {pcp_swap(f.txprio), 1'b0, e.vid};
          if (mask_hwtag[e.port] && !e.qinq)
            r.hw_tag_mode = 1'b1;
          else
            r.out_ethertype = e.qinq ? vtag_pkg::TPID_STAG : vtag_pkg::TPID_CTAG;
        end
      end
      default: r.verdict = vtag_pkg::V_NOT_VLAN;
    endcase
    return r;
  endfunction

  function automatic dir_row_t mk(input vtag_pkg::cmd_e c, input logic [2:0] port,
                                  input logic [3:0] idx, input logic [15:0] etype,
                                  input logic [15:0] tci, input logic hw,
                                  input logic shorth, input logic [47:0] mac,
                                  input logic [2:0] txprio, input logic [3:0] flags,
                                  input bit typed = 1'b0,
                                  input vtag_pkg::verdict_e v = vtag_pkg::V_DELIVER,
                                  input logic [3:0] mi = '0, input logic [11:0] vid = '0);
    dir_row_t d;
    d.cmd = c;
    d.f = '{flags: flags, txprio: txprio, mac: mac, shorth: shorth, hw: hw,
            tci: tci, etype: etype, idx: idx, port: port};
    d.typed = typed;
    d.want = '0;
    d.want.verdict     = v;
    d.want.match_index = mi;
    d.want.vlan_id     = vid;
    return d;
  endfunction

  function automatic logic [11:0] pick_vid();
    if ($urandom_range(0, 4) == 0)
      return 12'($urandom);
    return vid_pool[$urandom_range(0, 3)];
  endfunction

  task automatic cmp_field(input string name, input longint unsigned want,
                           input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic check_result(input vtag_pkg::result_t got, input vtag_pkg::result_t want);
    cmp_field("verdict", want.verdict, got.verdict);
    cmp_field("match_index", want.match_index, got.match_index);
    cmp_field("vlan_id", want.vlan_id, got.vlan_id);
    cmp_field("priority_res", want.priority_res, got.priority_res);
    cmp_field("hw_tag_mode", want.hw_tag_mode, got.hw_tag_mode);
    cmp_field("out_ethertype", want.out_ethertype, got.out_ethertype);
    cmp_field("out_tag_word", want.out_tag_word, got.out_tag_word);
  endtask

  // result side: every transfer is checked against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      if (exp_q.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_cnt++;
      end else begin
        check_result(vtag_pkg::result_t'(m_tdata), exp_q.pop_front());
      end
    end
  end

  // result-side ready: random stall bursts, plus one long hold-off on request
  initial begin : rx_ready_gen
    int n;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        for (n = 0; n < HoldOffCycles; n++) @(negedge clk);
        hold_off_req = 1'b0;
        m_tready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic drive_cmd(input vtag_pkg::cmd_e c, input cmd_fields_t f, input bit typed,
                           input vtag_pkg::result_t typed_res);
    vtag_pkg::result_t r;
    s_tvalid <= 1'b1;
    s_tdata  <= f;
    s_tuser  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // the shadow is updated in transfer order, so predict right here
    r = vlan_predict(c, f);
    exp_q.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  // stop offering and wait for every owed result
  task automatic drain();
    s_tvalid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input vtag_pkg::cfg_reg_e r, input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= v;
    case (r)
      vtag_pkg::REG_UP:      mask_up      = v;
      vtag_pkg::REG_RUNNING: mask_run     = v;
      vtag_pkg::REG_PROMISC: mask_promisc = v;
      default:               mask_hwtag   = v;
    endcase
    @(negedge clk);
  endtask

  // only called with the unit idle, at a falling edge
  task automatic set_masks(input logic [7:0] up, input logic [7:0] run,
                           input logic [7:0] prom, input logic [7:0] hwt);
    cfg_write(vtag_pkg::REG_UP, up);
    cfg_write(vtag_pkg::REG_RUNNING, run);
    cfg_write(vtag_pkg::REG_PROMISC, prom);
    cfg_write(vtag_pkg::REG_HWTAG, hwt);
    cfg_we <= 1'b0;
  endtask

  task automatic walk_rows();
    foreach (rows[i]) begin
      maybe_gap();
      drive_cmd(rows[i].cmd, rows[i].f, rows[i].typed, rows[i].want);
    end
    rows.delete();
  endtask

  // random command: mostly headers built to hit a valid entry, some noise
  task automatic rand_cmd(output vtag_pkg::cmd_e c, output cmd_fields_t f);
    int               sel, k, hit;
    vtag_pkg::entry_t e;
    f = {$urandom, $urandom, $urandom};
    sel = $urandom_range(0, 99);
    k = $urandom_range(0, NV - 1);
    hit = -1;
    for (int j = 0; j < NV; j++) begin
      if (hit < 0 && entry_tab[(k + j) % NV].valid)
        hit = (k + j) % NV;
    end
    if (sel < 20) begin
      c = vtag_pkg::CMD_WRITE;
      f.tci[11:0] = pick_vid();
      if ($urandom_range(0, 4) != 0)
        f.flags[0] = 1'b1;
    end else if (sel < 70) begin
      c = vtag_pkg::CMD_RX;
      if (hit >= 0 && $urandom_range(0, 9) < 7) begin
        e = entry_tab[hit];
        f.port = e.port;
        f.tci[11:0] = e.vid;
        f.shorth = ($urandom_range(0, 9) == 0);
        if (e.qinq) begin
          f.hw = 1'b0;
          f.etype = vtag_pkg::TPID_STAG;
        end else if ($urandom_range(0, 2) == 0) begin
          f.hw = 1'b1;
        end else begin
          f.hw = 1'b0;
          f.etype = vtag_pkg::TPID_CTAG;
        end
        // own mac, multicast, or some other unicast address
        case ($urandom_range(0, 2))
          0:       f.mac = mac_tab[hit];
          1:       f.mac[40] = 1'b1;
          default: f.mac[40] = 1'b0;
        endcase
      end else begin
        f.hw = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 2))
          0:       f.etype = vtag_pkg::TPID_CTAG;
          1:       f.etype = vtag_pkg::TPID_STAG;
          default: ;
        endcase
      end
    end else if (sel < 95) begin
      c = vtag_pkg::CMD_TX;
      if (hit >= 0 && $urandom_range(0, 9) < 7)
        f.idx = 4'(hit);
    end else begin
      c = vtag_pkg::CMD_NOP;
    end
  endtask

  initial begin : stimulus
    vtag_pkg::cmd_e c;
    cmd_fields_t    f;
    int             n;
    foreach (entry_tab[i]) begin
      entry_tab[i] = '0;
      mac_tab[i]   = '0;
    end
    mask_up = '0;
    mask_run = '0;
    mask_promisc = '0;
    mask_hwtag = '0;

    // reset first; the unit then sweeps its table with tready low
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // masks still at reset: all ports down, all entries invalid
    rows.push_back(mk(vtag_pkg::CMD_RX, 3'd0, 4'd0, 16'h0000, 16'h0000, 1'b0, 1'b0,
                      48'h0, 3'd0, 4'h0, 1'b1, vtag_pkg::V_PORT_DOWN));
    rows.push_back(mk(vtag_pkg::CMD_TX, 3'd0, 4'd0, 16'h0000, 16'h0000, 1'b0, 1'b0,
                      48'h0, 3'd0, 4'h0, 1'b1, vtag_pkg::V_TX_DOWN, 4'd0));
    rows.push_back(mk(vtag_pkg::CMD_NOP, 3'd7, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1,
                      '1, 3'd7, 4'hF, 1'b1, vtag_pkg::V_NOT_VLAN));
    rows.push_back(mk(vtag_pkg::CMD_WRITE, 3'd7, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1,
                      '1, 3'd7, 4'hF, 1'b1, vtag_pkg::V_WRITTEN, 4'd15, 12'hFFF));
    walk_rows();
    drain();

    // port 7 down, port 6 not running, all promiscuous, odd ports tag in hardware
    set_masks(8'h7F, 8'hBF, 8'hFF, 8'hAA);
    rows.push_back(mk(vtag_pkg::CMD_WRITE, 3'd1, 4'd0, 16'h0, 16'h0005, 1'b0, 1'b0,
                      48'h02000000000A, 3'd0, 4'h5));
    rows.push_back(mk(vtag_pkg::CMD_WRITE, 3'd1, 4'd1, 16'h0, 16'h0005, 1'b0, 1'b0,
                      48'h02000000000B, 3'd0, 4'h7));
    rows.push_back(mk(vtag_pkg::CMD_WRITE, 3'd2, 4'd2, 16'h0, 16'h0000, 1'b0, 1'b0,
                      48'h02000000000C, 3'd0, 4'h1));
    rows.push_back(mk(vtag_pkg::CMD_WRITE, 3'd2, 4'd3, 16'h0, 16'h0123, 1'b0, 1'b0,
                      48'h02000000000D, 3'd0, 4'hD));
    // duplicate of entry 0, must lose to the lower index
    rows.push_back(mk(vtag_pkg::CMD_WRITE, 3'd1, 4'd4, 16'h0, 16'h0005, 1'b0, 1'b0,
                      48'h02000000000E, 3'd0, 4'h5));
    rows.push_back(mk(vtag_pkg::CMD_WRITE, 3'd6, 4'd6, 16'h0, 16'h0007, 1'b0, 1'b0,
                      48'h02000000000E, 3'd0, 4'h5));
    // c-tag, own mac: deliver, priority 0 comes out as 1
    rows.push_back(mk(vtag_pkg::CMD_RX, 3'd1, 4'd0, vtag_pkg::TPID_CTAG, 16'h0005, 1'b0,
                      1'b0, 48'h02000000000A, 3'd0, 4'h0));
    // s-tag, foreign unicast on a promiscuous port: filtered
    rows.push_back(mk(vtag_pkg::CMD_RX, 3'd1, 4'd0, vtag_pkg::TPID_STAG, 16'h2005, 1'b0,
                      1'b0, 48'h020000000099, 3'd0, 4'h0));
    // s-tag, multicast passes the filter
    rows.push_back(mk(vtag_pkg::CMD_RX, 3'd1, 4'd0, vtag_pkg::TPID_STAG, 16'hE005, 1'b0,
                      1'b0, 48'h01005E000001, 3'd0, 4'h0));
    // hardware tag: ethertype and short header ignored, cfi bit set
    rows.push_back(mk(vtag_pkg::CMD_RX, 3'd1, 4'd0, 16'h1234, 16'hF005, 1'b1, 1'b1,
                      48'h02000000000A, 3'd0, 4'h0));
    rows.push_back(mk(vtag_pkg::CMD_RX, 3'd1, 4'd0, vtag_pkg::TPID_CTAG, 16'h0005, 1'b0,
                      1'b1, 48'h02000000000A, 3'd0, 4'h0, 1'b1, vtag_pkg::V_HDR_ERR));
    rows.push_back(mk(vtag_pkg::CMD_RX, 3'd1, 4'd0, 16'h0800, 16'h0005, 1'b0, 1'b0,
                      48'h02000000000A, 3'd0, 4'h0, 1'b1, vtag_pkg::V_NOT_VLAN));
    rows.push_back(mk(vtag_pkg::CMD_RX, 3'd7, 4'd0, vtag_pkg::TPID_CTAG, 16'h0FFF, 1'b0,
                      1'b0, 48'h02000000000A, 3'd0, 4'h0, 1'b1, vtag_pkg::V_PORT_DOWN));
    // entry valid but not up
    rows.push_back(mk(vtag_pkg::CMD_RX, 3'd2, 4'd0, vtag_pkg::TPID_CTAG, 16'h0000, 1'b0,
                      1'b0, 48'h02000000000C, 3'd0, 4'h0));
    // promiscuous entry takes any unicast
    rows.push_back(mk(vtag_pkg::CMD_RX, 3'd2, 4'd0, vtag_pkg::TPID_CTAG, 16'h4123, 1'b0,
                      1'b0, 48'hA4B2C3D4E5F6, 3'd0, 4'h0));
    rows.push_back(mk(vtag_pkg::CMD_RX, 3'd3, 4'd0, vtag_pkg::TPID_CTAG, 16'h0009, 1'b0,
                      1'b0, 48'h02000000000A, 3'd0, 4'h0));
    // transmit: hardware tag, inserted s-tag, inserted c-tag
    rows.push_back(mk(vtag_pkg::CMD_TX, 3'd0, 4'd0, 16'h0, 16'h0, 1'b0, 1'b0, 48'h0,
                      3'd0, 4'h0));
    rows.push_back(mk(vtag_pkg::CMD_TX, 3'd0, 4'd1, 16'h0, 16'h0, 1'b0, 1'b0, 48'h0,
                      3'd7, 4'h0));
    rows.push_back(mk(vtag_pkg::CMD_TX, 3'd0, 4'd3, 16'h0, 16'h0, 1'b0, 1'b0, 48'h0,
                      3'd1, 4'h0));
    rows.push_back(mk(vtag_pkg::CMD_TX, 3'd0, 4'd6, 16'h0, 16'h0, 1'b0, 1'b0, 48'h0,
                      3'd2, 4'h0, 1'b1, vtag_pkg::V_TX_DOWN, 4'd6));
    rows.push_back(mk(vtag_pkg::CMD_TX, 3'd0, 4'd9, 16'h0, 16'h0, 1'b0, 1'b0, 48'h0,
                      3'd2, 4'h0, 1'b1, vtag_pkg::V_TX_DOWN, 4'd9));
    rows.push_back(mk(vtag_pkg::CMD_TX, 3'd0, 4'd15, 16'h0, 16'h0, 1'b0, 1'b0, 48'h0,
                      3'd7, 4'h0, 1'b1, vtag_pkg::V_TX_DOWN, 4'd15));
    walk_rows();

    // random phases, each under its own mask setting
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0:       set_masks(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        1:       set_masks(8'h00, 8'h00, 8'h00, 8'h00);
        default: set_masks(8'($urandom | $urandom), 8'($urandom | $urandom),
                           8'($urandom), 8'($urandom));
      endcase
      // stretches with no idling, and none at all in the last phase
      tx_idle_en = !(ph == 3 || ph == 6);
      rx_idle_en = tx_idle_en;
      n = (ph == 1) ? 40 : 85;
      for (int k = 0; k < n; k++) begin
        // back-to-back transfers against a long result-side hold-off
        if (ph == 2 && k == 0)
          hold_off_req = 1'b1;
        if (ph == 4 && k == n / 2)
          drain();
        if (!(ph == 2 && k < 12))
          maybe_gap();
        rand_cmd(c, f);
        drive_cmd(c, f, 1'b0, '0);
      end
    end

    drain();
    repeat (NV + 8) @(posedge clk);
    if (fail_cnt == 0 && exp_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/vtag_pkg.sv
hdl/vtag_ram.sv
hdl/vlan_tag_classify_insert_unit.sv
tb/sv/testbench.sv
